// ===== sv/drt_pkg.sv =====
`timescale 1ns / 1ps
// Package for the device record table: sizes, record type and sequencer states.
package drt_pkg;

   localparam int ENTRIES    = 16;
   localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W      = $clog2(ENTRIES + 1);
   localparam int ADDR_W     = 56;
   localparam int STAMP_W    = 64;
   localparam int PRIO_W     = 8;
   localparam int STRENGTH_W = 8;
   localparam int SLOT_W     = 8;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_QUERY  = 1'b1;

   localparam logic signed [STAMP_W-1:0] STAMP_MIN = {1'b1, {(STAMP_W-1){1'b0}}};
   localparam logic signed [STAMP_W-1:0] STAMP_MAX = {1'b0, {(STAMP_W-1){1'b1}}};

   typedef struct packed {
      logic signed [STAMP_W-1:0]    stamp;
      logic        [PRIO_W-1:0]     prio;
      logic signed [STRENGTH_W-1:0] strength;
   } record_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN_ADDR,
      ST_DECIDE,
      ST_SCAN_STAMP,
      ST_RESPOND
   } state_type;

endpackage

// ===== sv/drt_if.sv =====
`timescale 1ns / 1ps
// Request and response channel interfaces of the device record table.
interface drt_req_if;
   import drt_pkg::*;
   logic                         valid;
   logic                         ready;
   logic                         mode;
   logic        [ADDR_W-1:0]     address;
   logic signed [STAMP_W-1:0]    stamp;
   logic        [PRIO_W-1:0]     prio;
   logic signed [STRENGTH_W-1:0] strength;
   modport source (output valid, mode, address, stamp, prio, strength, input ready);
   modport sink   (input valid, mode, address, stamp, prio, strength, output ready);
endinterface

interface drt_rsp_if;
   import drt_pkg::*;
   logic                      valid;
   logic                      ready;
   logic                      found;
   logic signed [STAMP_W-1:0] stamp_out;
   logic        [SLOT_W-1:0]  slot;
   logic        [SLOT_W-1:0]  oldest_slot;
   modport source (output valid, found, stamp_out, slot, oldest_slot, input ready);
   modport sink   (input valid, found, stamp_out, slot, oldest_slot, output ready);
endinterface

// ===== sv/device_record_table_oldest_replace.sv =====
`timescale 1ns / 1ps
// Device record table keyed by link-layer address, oldest-timestamp replacement.
//
// req_chan carries one beat per item: mode (insert or query), address, stamp,
// prio and strength. rsp_chan returns exactly one beat per item: found,
// stamp_out, slot and oldest_slot, in item order.
// Records live in two synchronous memories (addresses; stamp, prio, strength).
// An item is taken in IDLE, then the address memory is read one entry a cycle
// until the first match or the fill count is reached. An insert writes its
// record in the decide cycle and then rescans the stamp memory one entry a
// cycle for the smallest stamp. A query's response waits on one memory read pass,
// an insert's on two. The next beat is taken in the cycle the response appears.
// The response sits in an output register, so the next beat is accepted while
// the previous response is still held; a stalled receiver holds the block only
// when a second response is ready to be issued.
// Synchronous reset empties the table (fill count and oldest index to zero) and
// drops any pending response; memory contents are not cleared.
module device_record_table_oldest_replace (
   input  logic      clock,
   input  logic      reset,
   drt_req_if.sink   req_chan,
   drt_rsp_if.source rsp_chan
);
   import drt_pkg::*;

   state_type state_ff, state_in;

   logic                         mode_ff;
   logic        [ADDR_W-1:0]     addr_ff;
   logic signed [STAMP_W-1:0]    stamp_ff;
   logic        [PRIO_W-1:0]     prio_ff;
   logic signed [STRENGTH_W-1:0] strength_ff;

   logic [CNT_W-1:0]          cnt_ff;
   logic [IDX_W-1:0]          oldest_ff;
   logic [CNT_W-1:0]          issue_ff;
   logic                      pend_ff;
   logic [IDX_W-1:0]          pend_idx_ff;
   logic                      hit_ff;
   logic [IDX_W-1:0]          hit_idx_ff;
   logic signed [STAMP_W-1:0] hit_stamp_ff;
   logic signed [STAMP_W-1:0] best_ff;
   logic [IDX_W-1:0]          best_idx_ff;
   logic [IDX_W-1:0]          wr_slot_ff;

   logic [ADDR_W-1:0] addr_mem [ENTRIES];
   record_type        rec_mem  [ENTRIES];
   logic [ADDR_W-1:0] addr_q;
   record_type        rec_q;

   logic                      rsp_valid_ff;
   logic                      rsp_found_ff;
   logic signed [STAMP_W-1:0] rsp_stamp_ff;
   logic [SLOT_W-1:0]         rsp_slot_ff;
   logic [SLOT_W-1:0]         rsp_oldest_ff;

   logic             accept;
   logic             issue_go;
   logic             match;
   logic             scan_done;
   logic             rd_en;
   logic             out_free;
   logic             wr_en;
   logic             addr_wr_en;
   logic [IDX_W-1:0] wr_idx;
   logic             append;

   assign issue_go  = issue_ff < cnt_ff;
   assign match     = pend_ff && (addr_q == addr_ff);
   assign scan_done = !issue_go && !pend_ff;
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign accept    = req_chan.valid && req_chan.ready;
   assign append    = cnt_ff < CNT_W'(ENTRIES);

   always_comb begin
      state_in       = state_ff;
      req_chan.ready = 1'b0;
      rd_en          = 1'b0;
      wr_en          = 1'b0;
      addr_wr_en     = 1'b0;
      if (hit_ff) begin
         wr_idx = hit_idx_ff;
      end else if (append) begin
         wr_idx = cnt_ff[IDX_W-1:0];
      end else begin
         wr_idx = oldest_ff;
      end
      unique case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) state_in = ST_SCAN_ADDR;
         end
         ST_SCAN_ADDR: begin
            rd_en = issue_go;
            if (match || scan_done) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (mode_ff == MODE_QUERY) begin
               state_in = ST_RESPOND;
            end else begin
               wr_en      = 1'b1;
               addr_wr_en = !hit_ff;
               state_in   = ST_SCAN_STAMP;
            end
         end
         ST_SCAN_STAMP: begin
            rd_en = issue_go;
            if (scan_done) state_in = ST_RESPOND;
         end
         ST_RESPOND: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // address memory
   always_ff @(posedge clock) begin
      if (addr_wr_en) addr_mem[wr_idx] <= addr_ff;
      if (rd_en) addr_q <= addr_mem[issue_ff[IDX_W-1:0]];
   end

   // record memory
   always_ff @(posedge clock) begin
      if (wr_en) rec_mem[wr_idx] <= '{stamp: stamp_ff, prio: prio_ff, strength: strength_ff};
      if (rd_en) rec_q <= rec_mem[issue_ff[IDX_W-1:0]];
   end

   // item capture
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff     <= req_chan.mode;
         addr_ff     <= req_chan.address;
         stamp_ff    <= req_chan.stamp;
         prio_ff     <= req_chan.prio;
         strength_ff <= req_chan.strength;
      end
   end

   // scan sequencer and table control
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         oldest_ff   <= '0;
         issue_ff    <= '0;
         pend_ff     <= 1'b0;
         hit_ff      <= 1'b0;
         hit_idx_ff  <= '0;
         best_idx_ff <= '0;
         wr_slot_ff  <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               issue_ff <= '0;
               pend_ff  <= 1'b0;
               hit_ff   <= 1'b0;
            end
            ST_SCAN_ADDR: begin
               pend_ff     <= issue_go;
               pend_idx_ff <= issue_ff[IDX_W-1:0];
               if (issue_go) issue_ff <= issue_ff + CNT_W'(1);
               if (match) begin
                  hit_ff       <= 1'b1;
                  hit_idx_ff   <= pend_idx_ff;
                  hit_stamp_ff <= rec_q.stamp;
               end
            end
            ST_DECIDE: begin
               issue_ff    <= '0;
               pend_ff     <= 1'b0;
               best_ff     <= STAMP_MAX;
               best_idx_ff <= '0;
               if (mode_ff == MODE_INSERT) begin
                  wr_slot_ff <= wr_idx;
                  if (!hit_ff && append) cnt_ff <= cnt_ff + CNT_W'(1);
               end
            end
            ST_SCAN_STAMP: begin
               pend_ff     <= issue_go;
               pend_idx_ff <= issue_ff[IDX_W-1:0];
               if (issue_go) issue_ff <= issue_ff + CNT_W'(1);
               if (pend_ff && (rec_q.stamp < best_ff)) begin
                  best_ff     <= rec_q.stamp;
                  best_idx_ff <= pend_idx_ff;
               end
               if (scan_done) oldest_ff <= best_idx_ff;
            end
            ST_RESPOND: begin
            end
            default: begin
            end
         endcase
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_RESPOND && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_RESPOND && out_free) begin
         rsp_found_ff  <= hit_ff;
         rsp_oldest_ff <= SLOT_W'(oldest_ff);
         if (mode_ff == MODE_QUERY) begin
            rsp_stamp_ff <= hit_ff ? hit_stamp_ff : STAMP_MIN;
            rsp_slot_ff  <= hit_ff ? SLOT_W'(hit_idx_ff) : '0;
         end else begin
            rsp_stamp_ff <= stamp_ff;
            rsp_slot_ff  <= SLOT_W'(wr_slot_ff);
         end
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.found       = rsp_found_ff;
   assign rsp_chan.stamp_out   = rsp_stamp_ff;
   assign rsp_chan.slot        = rsp_slot_ff;
   assign rsp_chan.oldest_slot = rsp_oldest_ff;

endmodule

// ===== dv/drt_reply_checker.sv =====
`timescale 1ns / 1ps
// Checker for the device record table: predicts every reply and compares it.
module drt_reply_checker
   import drt_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic                         req_mode,
   input  logic        [ADDR_W-1:0]     req_address,
   input  logic signed [STAMP_W-1:0]    req_stamp,
   input  logic        [PRIO_W-1:0]     req_prio,
   input  logic signed [STRENGTH_W-1:0] req_strength,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic                         rsp_found,
   input  logic signed [STAMP_W-1:0]    rsp_stamp_out,
   input  logic        [SLOT_W-1:0]     rsp_slot,
   input  logic        [SLOT_W-1:0]     rsp_oldest_slot,
   output int                           fail_count,
   output int                           pending_replies
);

   typedef struct {
      logic                      found;
      logic signed [STAMP_W-1:0] stamp;
      logic        [SLOT_W-1:0]  slot;
      logic        [SLOT_W-1:0]  oldest;
   } table_reply_type;

   logic        [ADDR_W-1:0]     held_address  [ENTRIES];
   logic signed [STAMP_W-1:0]    held_stamp    [ENTRIES];
   logic        [PRIO_W-1:0]     held_prio     [ENTRIES];
   logic signed [STRENGTH_W-1:0] held_strength [ENTRIES];
   int                           held_count;
   int                           oldest_index;
   table_reply_type              expected_replies[$];

   initial begin
      fail_count      = 0;
      pending_replies = 0;
      held_count      = 0;
      oldest_index    = 0;
   end

   task automatic report_mismatch(string what, logic [STAMP_W-1:0] got,
                                  logic [STAMP_W-1:0] want);
      $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   function automatic table_reply_type predict_table_access(
      logic                         mode,
      logic        [ADDR_W-1:0]     address,
      logic signed [STAMP_W-1:0]    stamp,
      logic        [PRIO_W-1:0]     prio,
      logic signed [STRENGTH_W-1:0] strength
   );
      table_reply_type           r;
      int                        hit;
      int                        slot;
      logic signed [STAMP_W-1:0] best;
      hit = -1;
      for (int i = 0; i < held_count; i++)
         if (hit < 0 && held_address[i] == address) hit = i;
      r.found = (hit >= 0);
      if (mode == MODE_QUERY) begin
         r.stamp  = (hit >= 0) ? held_stamp[hit] : STAMP_MIN;
         r.slot   = (hit >= 0) ? SLOT_W'(hit) : '0;
         r.oldest = SLOT_W'(oldest_index);
         return r;
      end
      if (hit >= 0) begin
         slot = hit;
      end else if (held_count < ENTRIES) begin
         slot = held_count;
         held_count++;
         held_address[slot] = address;
      end else begin
         slot = (oldest_index < ENTRIES) ? oldest_index : 0;
         held_address[slot] = address;
      end
      held_stamp[slot]    = stamp;
      held_prio[slot]     = prio;
      held_strength[slot] = strength;
      // strict less-than keeps the lowest index on a tie
      best         = STAMP_MAX;
      oldest_index = 0;
      for (int i = 0; i < held_count; i++) begin
         if (held_stamp[i] < best) begin
            best         = held_stamp[i];
            oldest_index = i;
         end
      end
      r.stamp  = stamp;
      r.slot   = SLOT_W'(slot);
      r.oldest = SLOT_W'(oldest_index);
      return r;
   endfunction

   always @(posedge clock) begin
      table_reply_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_replies.size() == 0) begin
               report_mismatch("unexpected reply beat", rsp_stamp_out, '0);
            end else begin
               want = expected_replies.pop_front();
               if (rsp_found !== want.found)
                  report_mismatch("found", rsp_found, want.found);
               if (rsp_stamp_out !== want.stamp)
                  report_mismatch("stamp_out", rsp_stamp_out, want.stamp);
               if (rsp_slot !== want.slot)
                  report_mismatch("slot", rsp_slot, want.slot);
               if (rsp_oldest_slot !== want.oldest)
                  report_mismatch("oldest_slot", rsp_oldest_slot, want.oldest);
            end
         end
         if (req_valid && req_ready)
            expected_replies.push_back(predict_table_access(req_mode, req_address,
                                                            req_stamp, req_prio,
                                                            req_strength));
         pending_replies <= expected_replies.size();
      end
   end

endmodule

// ===== dv/device_record_table_oldest_replace_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the device record table: stimulus, back-pressure and verdict.
module device_record_table_oldest_replace_tb;
   import drt_pkg::*;

   localparam int RANDOM_ITEMS   = 500;
   localparam int CALM_ITEMS     = 60;
   localparam int POOL_SIZE      = 24;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 3000;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_replies;
   int   sent_count;
   int   quiet_cycles;
   bit   calm;
   bit   held_once;

   drt_req_if req_chan ();
   drt_rsp_if rsp_chan ();

   device_record_table_oldest_replace u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   drt_reply_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_chan.valid),
      .req_ready       (req_chan.ready),
      .req_mode        (req_chan.mode),
      .req_address     (req_chan.address),
      .req_stamp       (req_chan.stamp),
      .req_prio        (req_chan.prio),
      .req_strength    (req_chan.strength),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_found       (rsp_chan.found),
      .rsp_stamp_out   (rsp_chan.stamp_out),
      .rsp_slot        (rsp_chan.slot),
      .rsp_oldest_slot (rsp_chan.oldest_slot),
      .fail_count      (fail_count),
      .pending_replies (pending_replies)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   function automatic logic [STAMP_W-1:0] rand_bits64();
      return {$urandom, $urandom};
   endfunction

   task automatic send_item(logic mode, logic [ADDR_W-1:0] address,
                            logic signed [STAMP_W-1:0] stamp, logic [PRIO_W-1:0] prio,
                            logic signed [STRENGTH_W-1:0] strength);
      int gap;
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 8);
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.mode     <= mode;
      req_chan.address  <= address;
      req_chan.stamp    <= stamp;
      req_chan.prio     <= prio;
      req_chan.strength <= strength;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sent_count++;
   endtask

   // receiver: random stall bursts, one long hold-off to fill the block
   initial begin
      int n;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held_once && sent_count >= 30) begin
            held_once = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 8);
            rsp_chan.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end else begin
            n = $urandom_range(1, 16);
            rsp_chan.ready <= 1'b1;
            repeat (n) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic        [ADDR_W-1:0]  pool [POOL_SIZE];
      logic        [ADDR_W-1:0]  address;
      logic signed [STAMP_W-1:0] stamp;
      logic                      mode;
      int                        pick;
      sent_count   = 0;
      quiet_cycles = 0;
      calm         = 1'b0;
      held_once    = 1'b0;
      reset             <= 1'b1;
      req_chan.valid    <= 1'b0;
      req_chan.mode     <= MODE_INSERT;
      req_chan.address  <= '0;
      req_chan.stamp    <= '0;
      req_chan.prio     <= '0;
      req_chan.strength <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, extremes, updates, fill, full-table replacement
      send_item(MODE_QUERY,  '0, STAMP_MAX, 8'hFF, 8'sh7F);
      send_item(MODE_INSERT, '0, STAMP_MAX, 8'h00, -8'sd128);
      send_item(MODE_INSERT, '1, STAMP_MIN, 8'hFF, 8'sd127);
      send_item(MODE_QUERY,  '1, '0, '0, '0);
      send_item(MODE_INSERT, '0, STAMP_MIN, 8'h5A, -8'sd1);
      send_item(MODE_INSERT, '1, STAMP_MAX, 8'hA5, 8'sd1);
      send_item(MODE_QUERY,  '0, STAMP_MAX, '0, '0);
      for (int i = 2; i < ENTRIES; i++)
         send_item(MODE_INSERT, {8'(i), 48'hA5A5_0000_0000 + 48'(i)},
                   64'sd10 + STAMP_W'(i % 3), 8'(i), 8'(i));
      send_item(MODE_INSERT, 56'h12_3456_789A_BCDE, 64'sd5, 8'h33, -8'sd50);
      send_item(MODE_QUERY,  '0, '0, '0, '0);
      send_item(MODE_QUERY,  56'h12_3456_789A_BCDE, '0, '0, '0);
      send_item(MODE_INSERT, 56'h77_0000_0000_0001, 64'sd20, 8'h01, 8'sd3);

      for (int i = 0; i < POOL_SIZE; i++)
         pool[i] = ADDR_W'(rand_bits64());

      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
         mode = ($urandom_range(0, 2) == 0) ? MODE_QUERY : MODE_INSERT;
         if ($urandom_range(0, 19) < 17)
            address = pool[$urandom_range(0, POOL_SIZE - 1)];
         else
            address = ADDR_W'(rand_bits64());
         pick = $urandom_range(0, 7);
         case (pick)
            0: stamp = STAMP_MIN;
            1: stamp = STAMP_MAX;
            2, 3: stamp = STAMP_W'($urandom_range(0, 7));
            4, 5: stamp = rand_bits64();
            default: stamp = STAMP_W'(signed'($urandom)) >>> $urandom_range(0, 16);
         endcase
         send_item(mode, address, stamp, 8'($urandom), 8'($urandom));
      end
      req_chan.valid <= 1'b0;

      while (pending_replies != 0 || u_checker_busy()) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // pending_replies is a registered copy of the queue size; also wait while a beat is accepted
   function automatic bit u_checker_busy();
      return (req_chan.valid && req_chan.ready);
   endfunction

endmodule

// ===== device_record_table_oldest_replace.f =====
sv/drt_pkg.sv
sv/drt_if.sv
sv/device_record_table_oldest_replace.sv
dv/drt_reply_checker.sv
dv/device_record_table_oldest_replace_tb.sv
